[rtl/core/afspf_pkg.sv]
// Shared types, constants and helpers of the frequency scan peak finder.
`timescale 1ns / 1ps
`default_nettype none

package afspf_pkg;

   // Field widths
   localparam int FREQ_W     = 25;
   localparam int STEP_W     = 20;
   localparam int LEVEL_W    = 5;
   localparam int INDEX_W    = 8;
   localparam int CSR_ADDR_W = 2;

   // Default peak table size
   localparam int MAX_PEAKS_DEF = 256;

   // Stream payload layout
   localparam int REQ_TDATA_W   = 16;
   localparam int RSP_FIELDS_W  = 3 * FREQ_W + 3 * LEVEL_W + INDEX_W + 1;
   localparam int RSP_TDATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_ERROR_BIT = RSP_FIELDS_W - 1;

   typedef logic [FREQ_W-1:0]  freq_type;
   typedef logic [LEVEL_W-1:0] level_type;

   localparam freq_type FREQ_MAX       = '1;
   localparam freq_type FIRST_FREQ_RST = 25'd100;
   localparam freq_type LAST_FREQ_RST  = 25'd0;
   localparam logic [STEP_W-1:0] BIG_STEP_RST   = 20'd300;
   localparam logic [STEP_W-1:0] SMALL_STEP_RST = 20'd150;

   // Reply characters: silent marker and first level letter
   localparam logic [7:0] CHAR_SILENT     = 8'h25;
   localparam logic [7:0] CHAR_LEVEL_BASE = 8'h41;
   localparam logic [7:0] LEVEL_TOP_OFS   = 8'd15;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FIRST_FREQ = 2'd0,
      CSR_LAST_FREQ  = 2'd1,
      CSR_BIG_STEP   = 2'd2,
      CSR_SMALL_STEP = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_SET_FREQ  = 3'd0,
      KIND_GET_LEVEL = 3'd1,
      KIND_PEAK      = 3'd2,
      KIND_DONE      = 3'd3,
      KIND_NONE      = 3'd4
   } kind_type;

   typedef enum logic {
      PH_FALLING = 1'b0,
      PH_RISING  = 1'b1
   } phase_type;

   // Peak detector state
   typedef struct packed {
      logic      first_pending;
      phase_type phase;
      freq_type  prev_freq;
      level_type prev_level;
      freq_type  rise_freq;
      level_type rise_level;
      freq_type  top_freq;
      level_type top_level;
   } det_type;

   // One detected peak
   typedef struct packed {
      freq_type               end_freq;
      freq_type               start_freq;
      level_type              start_level;
      freq_type               top_freq;
      level_type              power;
      level_type              end_level;
      logic [INDEX_W-1:0]     index;
   } peak_type;

   // One result transaction
   typedef struct packed {
      kind_type           kind;
      logic               last;
      logic               error;
      logic [INDEX_W-1:0] index;
      level_type          end_level;
      level_type          power;
      freq_type           top_freq;
      level_type          start_level;
      freq_type           start_freq;
      freq_type           freq;
   } res_type;

   // Frequency add that clips at the top code
   function automatic freq_type sat_add(freq_type a, freq_type b);
      logic [FREQ_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[FREQ_W] ? FREQ_MAX : sum[FREQ_W-1:0];
   endfunction

   // Peak record as a result transaction
   function automatic res_type peak_res(peak_type p, logic err);
      res_type r;
      r.kind        = KIND_PEAK;
      r.last        = 1'b0;
      r.error       = err;
      r.index       = p.index;
      r.end_level   = p.end_level;
      r.power       = p.power;
      r.top_freq    = p.top_freq;
      r.start_level = p.start_level;
      r.start_freq  = p.start_freq;
      r.freq        = p.end_freq;
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/afspf_detect.sv]
// Rise-fall-rise peak detector for one level sample.
`timescale 1ns / 1ps
`default_nettype none

module afspf_detect
   import afspf_pkg::*;
#(
   parameter int  MAX_PEAKS = MAX_PEAKS_DEF,
   localparam int PCW       = $clog2(MAX_PEAKS + 1)
) (
   input  wire logic           en,
   input  wire freq_type       s_freq,
   input  wire level_type      s_level,
   input  wire det_type        det_cur,
   input  wire logic [PCW-1:0] count_cur,
   output det_type             det_nxt,
   output logic [PCW-1:0]      count_nxt,
   output logic                peak_valid,
   output peak_type            peak
);

   // Record of the peak closed by this sample
   always_comb begin
      peak.end_freq    = det_cur.prev_freq;
      peak.start_freq  = det_cur.rise_freq;
      peak.start_level = det_cur.rise_level;
      peak.top_freq    = det_cur.top_freq;
      peak.power       = det_cur.top_level;
      peak.end_level   = det_cur.prev_level;
      peak.index       = INDEX_W'(count_cur);
   end

   // Phase update; the very first sample only primes the history
   always_comb begin
      det_nxt    = det_cur;
      count_nxt  = count_cur;
      peak_valid = 1'b0;
      if (en) begin
         if (det_cur.first_pending) begin
            det_nxt.first_pending = 1'b0;
         end else if (det_cur.phase == PH_FALLING &&
                      (s_level > det_cur.prev_level || s_level == '0)) begin
            if (det_cur.top_level != '0 && count_cur < PCW'(MAX_PEAKS)) begin
               peak_valid = 1'b1;
               count_nxt  = count_cur + PCW'(1);
            end
            det_nxt.phase      = PH_RISING;
            det_nxt.rise_freq  = s_freq;
            det_nxt.rise_level = s_level;
         end else if (det_cur.phase == PH_RISING && s_level == '0) begin
            det_nxt.rise_freq  = s_freq;
            det_nxt.rise_level = s_level;
         end else if (det_cur.phase == PH_RISING && s_level < det_cur.prev_level) begin
            det_nxt.phase     = PH_FALLING;
            det_nxt.top_freq  = det_cur.prev_freq;
            det_nxt.top_level = det_cur.prev_level;
         end
         det_nxt.prev_freq  = s_freq;
         det_nxt.prev_level = s_level;
      end
   end

endmodule

`default_nettype wire

[rtl/core/afspf_core.sv]
// Sweep control: registers, reply decode, frequency stepping and result list.
`timescale 1ns / 1ps
`default_nettype none

module afspf_core
   import afspf_pkg::*;
#(
   parameter int MAX_PEAKS = MAX_PEAKS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wen,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [FREQ_W-1:0]     csr_wdata,
   input  wire logic                  item_valid,
   input  wire logic                  item_op,
   input  wire logic [7:0]            item_len,
   input  wire logic [7:0]            item_char,
   output res_type [2:0]              res_list,
   output logic [1:0]                 res_count
);

   localparam int PCW = $clog2(MAX_PEAKS + 1);

   typedef enum logic [1:0] {
      MODE_SET  = 2'd0,
      MODE_GET  = 2'd1,
      MODE_END  = 2'd2,
      MODE_INIT = 2'd3
   } mode_type;

   // Configuration registers
   freq_type            first_freq_ff, last_freq_ff;
   logic [STEP_W-1:0]   big_step_ff, small_step_ff;

   // Scan state
   mode_type            mode_ff, mode_in;
   det_type             det_ff, det_in;
   logic [PCW-1:0]      count_ff, count_in;
   freq_type            cur_freq_ff, cur_freq_in;
   level_type           cur_level_ff, cur_level_in;
   freq_type            saved_freq_ff, saved_freq_in;
   level_type           saved_level_ff, saved_level_in;
   freq_type            fine_freq_ff, fine_freq_in;
   logic                error_ff, error_in;

   // State after the start/reply has been applied
   mode_type            w_mode;
   det_type             w_det;
   logic [PCW-1:0]      w_count;
   freq_type            w_freq, w_saved_freq, w_fine;
   level_type           w_level, w_saved_level;

   logic                level_ok, rep_err, step_ok, beyond, in_get;
   level_type           reply_level;
   logic                quiet, back_up, done, hit;
   freq_type            base, step_one, step_two, nxt_freq, clamp_freq, end_freq;
   freq_type            saved_freq_eff;
   level_type           saved_level_eff, level_nxt;
   kind_type            cmd_kind;
   freq_type            cmd_freq;
   res_type             res_cmd;

   // Detector chain: up to two samples per transaction
   logic                s1_en, s2_en;
   det_type             det_a_nxt, det_b_nxt;
   logic [PCW-1:0]      count_a_nxt, count_b_nxt;
   logic                peak_a_v, peak_b_v;
   peak_type            peak_a, peak_b;

   afspf_detect #(.MAX_PEAKS(MAX_PEAKS)) u_det_a (
      .en         (s1_en),
      .s_freq     (w_freq),
      .s_level    (w_level),
      .det_cur    (w_det),
      .count_cur  (w_count),
      .det_nxt    (det_a_nxt),
      .count_nxt  (count_a_nxt),
      .peak_valid (peak_a_v),
      .peak       (peak_a)
   );

   afspf_detect #(.MAX_PEAKS(MAX_PEAKS)) u_det_b (
      .en         (s2_en),
      .s_freq     (step_one),
      .s_level    (saved_level_eff),
      .det_cur    (det_a_nxt),
      .count_cur  (count_a_nxt),
      .det_nxt    (det_b_nxt),
      .count_nxt  (count_b_nxt),
      .peak_valid (peak_b_v),
      .peak       (peak_b)
   );

   // Reply decode and start handling
   always_comb begin
      level_ok    = (item_char >= CHAR_LEVEL_BASE) &&
                    (item_char <= CHAR_LEVEL_BASE + LEVEL_TOP_OFS);
      reply_level = 5'(item_char - CHAR_LEVEL_BASE) + 5'd1;

      rep_err = 1'b0;
      if (item_op) begin
         if (mode_ff == MODE_SET) begin
            rep_err = (item_len != 8'd0);
         end else if (mode_ff == MODE_GET) begin
            rep_err = (item_len != 8'd1) || (item_char != CHAR_SILENT && !level_ok);
         end
      end
      step_ok = !error_ff && !rep_err;

      w_mode        = mode_ff;
      w_det         = det_ff;
      w_count       = count_ff;
      w_freq        = cur_freq_ff;
      w_level       = cur_level_ff;
      w_saved_freq  = saved_freq_ff;
      w_saved_level = saved_level_ff;
      w_fine        = fine_freq_ff;
      if (!item_op) begin
         w_mode                 = MODE_INIT;
         w_det.first_pending    = 1'b1;
         w_det.phase            = PH_FALLING;
         w_det.prev_freq        = first_freq_ff;
         w_det.prev_level       = '0;
         w_det.top_level        = '0;
         w_count                = '0;
         w_freq                 = first_freq_ff;
         w_level                = '0;
         w_saved_freq           = '0;
         w_saved_level          = '0;
         w_fine                 = first_freq_ff;
      end else if (mode_ff == MODE_GET) begin
         w_level = (item_char == CHAR_SILENT) ? '0 : reply_level;
      end
   end

   // Frequency stepping for a level reply
   always_comb begin
      beyond          = w_freq > last_freq_ff;
      in_get          = step_ok && !beyond && (w_mode == MODE_GET);
      quiet           = (w_level == '0);
      back_up         = !quiet && (w_freq > w_fine);
      base            = back_up ? w_fine : w_freq;
      done            = base >= last_freq_ff;
      step_one        = sat_add(base, quiet ? FREQ_W'(big_step_ff) : FREQ_W'(small_step_ff));
      // two small steps in one add; clipping is monotonic so this matches two clipped adds
      step_two        = sat_add(base, FREQ_W'({small_step_ff, 1'b0}));
      saved_freq_eff  = back_up ? w_freq : w_saved_freq;
      saved_level_eff = back_up ? w_level : w_saved_level;
      hit             = !quiet && !done && (step_one == saved_freq_eff);
      level_nxt       = hit ? saved_level_eff : w_level;
      nxt_freq        = hit ? step_two : step_one;
      clamp_freq      = (nxt_freq > last_freq_ff) ? last_freq_ff : nxt_freq;
      end_freq        = sat_add(last_freq_ff, FREQ_W'(1));
      s1_en           = in_get && (quiet || !back_up);
      s2_en           = in_get && hit;
   end

   // Next state and command
   always_comb begin
      mode_in        = w_mode;
      det_in         = w_det;
      count_in       = w_count;
      cur_freq_in    = w_freq;
      cur_level_in   = w_level;
      saved_freq_in  = w_saved_freq;
      saved_level_in = w_saved_level;
      fine_freq_in   = w_fine;
      error_in       = error_ff | rep_err;
      cmd_kind       = KIND_NONE;
      cmd_freq       = error_ff ? cur_freq_ff : w_freq;

      if (step_ok && !beyond) begin
         unique case (w_mode)
            MODE_INIT: begin
               mode_in     = MODE_SET;
               cur_freq_in = first_freq_ff;
               cmd_kind    = KIND_SET_FREQ;
               cmd_freq    = first_freq_ff;
            end
            MODE_SET: begin
               mode_in  = MODE_GET;
               cmd_kind = KIND_GET_LEVEL;
               cmd_freq = '0;
            end
            MODE_END: begin
               // sweep over: nothing to send
            end
            MODE_GET: begin
               det_in         = det_b_nxt;
               count_in       = count_b_nxt;
               cur_level_in   = level_nxt;
               saved_freq_in  = saved_freq_eff;
               saved_level_in = saved_level_eff;
               if (done) begin
                  mode_in      = MODE_END;
                  cur_freq_in  = end_freq;
                  fine_freq_in = quiet ? w_freq : w_fine;
                  cmd_kind     = KIND_DONE;
                  cmd_freq     = end_freq;
               end else begin
                  mode_in      = MODE_SET;
                  cur_freq_in  = clamp_freq;
                  fine_freq_in = (level_nxt != '0) ? clamp_freq : (quiet ? w_freq : w_fine);
                  cmd_kind     = KIND_SET_FREQ;
                  cmd_freq     = clamp_freq;
               end
            end
            default: begin
               mode_in = w_mode;
            end
         endcase
      end
   end

   // Result list: peak records first, command last
   always_comb begin
      res_cmd       = '0;
      res_cmd.kind  = cmd_kind;
      res_cmd.last  = 1'b1;
      res_cmd.error = error_in;
      res_cmd.freq  = cmd_freq;

      res_list = {res_cmd, res_cmd, res_cmd};
      if (peak_a_v && peak_b_v) begin
         res_list[0] = peak_res(peak_a, error_in);
         res_list[1] = peak_res(peak_b, error_in);
         res_count   = 2'd3;
      end else if (peak_a_v) begin
         res_list[0] = peak_res(peak_a, error_in);
         res_count   = 2'd2;
      end else if (peak_b_v) begin
         res_list[0] = peak_res(peak_b, error_in);
         res_count   = 2'd2;
      end else begin
         res_count   = 2'd1;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         first_freq_ff <= FIRST_FREQ_RST;
         last_freq_ff  <= LAST_FREQ_RST;
         big_step_ff   <= BIG_STEP_RST;
         small_step_ff <= SMALL_STEP_RST;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_FIRST_FREQ: first_freq_ff <= csr_wdata;
            CSR_LAST_FREQ:  last_freq_ff  <= csr_wdata;
            CSR_BIG_STEP:   big_step_ff   <= csr_wdata[STEP_W-1:0];
            CSR_SMALL_STEP: small_step_ff <= csr_wdata[STEP_W-1:0];
            default:        first_freq_ff <= first_freq_ff;
         endcase
      end
   end

   // Scan state; a reply error only raises the sticky flag
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff              <= MODE_INIT;
         det_ff.first_pending <= 1'b1;
         det_ff.phase         <= PH_FALLING;
         det_ff.prev_freq     <= FIRST_FREQ_RST;
         det_ff.prev_level    <= '0;
         det_ff.rise_freq     <= '0;
         det_ff.rise_level    <= '0;
         det_ff.top_freq      <= '0;
         det_ff.top_level     <= '0;
         count_ff             <= '0;
         cur_freq_ff          <= FIRST_FREQ_RST;
         cur_level_ff         <= '0;
         saved_freq_ff        <= '0;
         saved_level_ff       <= '0;
         fine_freq_ff         <= FIRST_FREQ_RST;
         error_ff             <= 1'b0;
      end else if (item_valid) begin
         error_ff <= error_in;
         if (step_ok) begin
            mode_ff        <= mode_in;
            det_ff         <= det_in;
            count_ff       <= count_in;
            cur_freq_ff    <= cur_freq_in;
            cur_level_ff   <= cur_level_in;
            saved_freq_ff  <= saved_freq_in;
            saved_level_ff <= saved_level_in;
            fine_freq_ff   <= fine_freq_in;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/core/afspf_rbuf.sv]
// Three-entry result buffer that drains one result transaction per cycle while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module afspf_rbuf
   import afspf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  wire logic [1:0]    load_count,
   input  wire res_type [2:0] load_list,
   input  wire logic          out_ready,
   output logic               out_valid,
   output res_type            out_head,
   output logic               free
);

   logic [1:0]    count_ff, count_in;
   res_type [2:0] slot_ff, slot_in;
   logic          pop;

   assign out_valid = (count_ff != 2'd0);
   assign out_head  = slot_ff[0];
   assign pop       = out_valid && out_ready;
   // room for a new list when empty or when the last entry leaves now
   assign free      = (count_ff == 2'd0) || (count_ff == 2'd1 && out_ready);

   // Load a whole list, or shift toward the head on each pop
   always_comb begin
      count_in = count_ff;
      slot_in  = slot_ff;
      if (load) begin
         count_in = load_count;
         slot_in  = load_list;
      end else if (pop) begin
         count_in   = count_ff - 2'd1;
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

[rtl/core/adaptive_frequency_scan_peak_finder.sv]
// Path: a request is registered in the input register at accept; when the result buffer is free,
// its results load the buffer, and the first result is then presented from the buffer register.
// Throughput: an item's results (1 to 3) hold the three-entry buffer until all are taken;
// with single-result items and rsp_tready high, one request is taken every cycle.
// Reset: synchronous, active high; registers return to their defaults, the scan to its start
// state and the sticky error flag clears. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module adaptive_frequency_scan_peak_finder
   import afspf_pkg::*;
#(
   parameter int MAX_PEAKS = MAX_PEAKS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,   // reply_len[7:0], reply_char[15:8]
   input  wire logic                   req_tuser,   // op
   // result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,   // freq, peak_start_freq, peak_start_level,
                                                    // peak_top_freq, peak_power, peak_end_level,
                                                    // peak_index, error, zero pad
   output logic [2:0]                  rsp_tuser,   // kind
   output logic                        rsp_tlast,   // last
   // register writes
   input  wire logic                   csr_wen,
   input  wire logic [CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [FREQ_W-1:0]      csr_wdata
);

   logic          in_valid_ff;
   logic          in_op_ff;
   logic [7:0]    in_len_ff, in_char_ff;
   logic          take, buf_free;
   res_type [2:0] res_list;
   logic [1:0]    res_count;
   res_type       head;

   assign take       = in_valid_ff && buf_free;
   assign req_tready = !in_valid_ff || take;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (take) begin
         in_valid_ff <= 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_op_ff   <= req_tuser;
         in_len_ff  <= req_tdata[7:0];
         in_char_ff <= req_tdata[15:8];
      end
   end

   afspf_core #(.MAX_PEAKS(MAX_PEAKS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .item_valid (take),
      .item_op    (in_op_ff),
      .item_len   (in_len_ff),
      .item_char  (in_char_ff),
      .res_list   (res_list),
      .res_count  (res_count)
   );

   afspf_rbuf u_rbuf (
      .clock      (clock),
      .reset      (reset),
      .load       (take),
      .load_count (res_count),
      .load_list  (res_list),
      .out_ready  (rsp_tready),
      .out_valid  (rsp_tvalid),
      .out_head   (head),
      .free       (buf_free)
   );

   // Result packing
   assign rsp_tdata = {{(RSP_TDATA_W - RSP_FIELDS_W){1'b0}},
                       head.error, head.index, head.end_level, head.power,
                       head.top_freq, head.start_level, head.start_freq, head.freq};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule

`default_nettype wire

[rtl/core/afspf_chk.sv]
// Port-level checker for the scan peak finder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module afspf_chk
   import afspf_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [2:0]             rsp_tuser,
   input wire logic                   rsp_tlast
);

   logic err_seen_ff, err_seen_in;

   // Remember a delivered error result
   assign err_seen_in = err_seen_ff ||
                        (rsp_tvalid && rsp_tready && rsp_tdata[RSP_ERROR_BIT]);

   always_ff @(posedge clock) begin
      if (reset) begin
         err_seen_ff <= 1'b0;
      end else begin
         err_seen_ff <= err_seen_in;
      end
   end

   // Peak records precede the closing transaction of an item
   a_peak_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tuser == KIND_PEAK) == !rsp_tlast))
      else $error("peak record and tlast disagree");

   // Once in error, nothing but empty results
   a_error_none: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_ERROR_BIT] |-> rsp_tuser == KIND_NONE)
      else $error("error result with a command or peak");

   // Error flag stays set until reset
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && err_seen_ff |-> rsp_tdata[RSP_ERROR_BIT])
      else $error("error flag dropped without reset");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

endmodule

bind adaptive_frequency_scan_peak_finder afspf_chk u_afspf_chk (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

[bench/adaptive_frequency_scan_peak_finder_tb.sv]
// Self-checking testbench for the adaptive frequency scan peak finder.
`timescale 1ns / 1ps

module adaptive_frequency_scan_peak_finder_tb;
   import afspf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int PEAK_SLOTS  = MAX_PEAKS_DEF;
   localparam int IDLE_PCT    = 16;

   // Request opcodes and reply lengths
   localparam logic       OP_START  = 1'b0;
   localparam logic       OP_REPLY  = 1'b1;
   localparam logic [7:0] ACK_LEN   = 8'd0;
   localparam logic [7:0] LEVEL_LEN = 8'd1;

   // Response payload bit offsets, lowest field first
   localparam int SFREQ_LO = FREQ_W;
   localparam int SLVL_LO  = 2 * FREQ_W;
   localparam int TFREQ_LO = SLVL_LO + LEVEL_W;
   localparam int POWER_LO = TFREQ_LO + FREQ_W;
   localparam int ELVL_LO  = POWER_LO + LEVEL_W;
   localparam int INDEX_LO = ELVL_LO + LEVEL_W;

   typedef enum logic [1:0] {
      SCAN_SET  = 2'd0,
      SCAN_GET  = 2'd1,
      SCAN_END  = 2'd2,
      SCAN_INIT = 2'd3
   } sweep_mode_type;

   typedef struct packed {
      logic       op;
      logic [7:0] len;
      logic [7:0] ch;
   } scan_item_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // reply_len[7:0], reply_char[15:8]
   logic                   req_tuser = 1'b0; // op
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // freq, peak_start_freq, peak_start_level,
                                             // peak_top_freq, peak_power, peak_end_level,
                                             // peak_index, error, zero pad
   logic [2:0]             rsp_tuser;        // kind
   logic                   rsp_tlast;        // last
   logic                   csr_wen = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [FREQ_W-1:0]      csr_wdata = '0;

   adaptive_frequency_scan_peak_finder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Stimulus and scoreboard storage
   scan_item_type items_to_send[$];
   scan_item_type item_on_bus;
   res_type       pending_results[$];
   res_type       step_out[$];
   res_type       oldest;
   int            mismatches = 0;
   int            cycle_count = 0;
   bit            steady = 1'b0;
   int            holds_asked = 0;
   int            holds_served = 0;
   int            hold_left = 0;

   // Predictor registers
   freq_type          cfg_first, cfg_last;
   logic [STEP_W-1:0] cfg_big, cfg_small;

   // Predictor sweep and detector state
   sweep_mode_type mode_now;
   phase_type      slope;
   bit             skip_first;
   bit             sticky_err;
   freq_type       cur_freq, prev_freq, park_freq, retry_freq, rise_freq, crest_freq;
   level_type      cur_lvl, prev_lvl, park_lvl, rise_lvl, crest_lvl;
   logic [8:0]     peaks_found;

   initial begin
      forever #10 clock = ~clock;
   end

   // Frequency sum clipped at the top code
   function automatic freq_type clip_sum(freq_type a, freq_type b);
      logic [FREQ_W:0] total;
      total = {1'b0, a} + {1'b0, b};
      if (total > {1'b0, {FREQ_W{1'b1}}})
         return {FREQ_W{1'b1}};
      return total[FREQ_W-1:0];
   endfunction

   function automatic res_type plain_result(kind_type k, freq_type f);
      res_type r;
      r = '0;
      r.kind = k;
      r.freq = f;
      return r;
   endfunction

   // At most three results per request
   function automatic void add_result(res_type r);
      if (step_out.size() < 3)
         step_out.push_back(r);
   endfunction

   // Rise-fall-rise peak tracker
   function automatic void detect_peak();
      res_type r;
      if (skip_first) begin
         skip_first = 1'b0;
         return;
      end
      if (slope == PH_FALLING && (cur_lvl > prev_lvl || cur_lvl == 0)) begin
         if (crest_lvl > 0 && peaks_found < PEAK_SLOTS) begin
            r = plain_result(KIND_PEAK, prev_freq);
            r.start_freq  = rise_freq;
            r.start_level = rise_lvl;
            r.top_freq    = crest_freq;
            r.power       = crest_lvl;
            r.end_level   = prev_lvl;
            r.index       = peaks_found[INDEX_W-1:0];
            peaks_found++;
            add_result(r);
         end
         slope     = PH_RISING;
         rise_freq = cur_freq;
         rise_lvl  = cur_lvl;
         return;
      end
      if (slope == PH_RISING && cur_lvl == 0) begin
         rise_freq = cur_freq;
         rise_lvl  = cur_lvl;
         return;
      end
      if (slope == PH_RISING && cur_lvl < prev_lvl) begin
         slope      = PH_FALLING;
         crest_freq = prev_freq;
         crest_lvl  = prev_lvl;
      end
   endfunction

   function automatic void take_sample();
      detect_peak();
      prev_freq = cur_freq;
      prev_lvl  = cur_lvl;
   endfunction

   function automatic void end_sweep();
      cur_freq = clip_sum(cfg_last, freq_type'(1));
      mode_now = SCAN_END;
      add_result(plain_result(KIND_DONE, cur_freq));
   endfunction

   function automatic void clear_scan();
      slope       = PH_FALLING;
      mode_now    = SCAN_INIT;
      peaks_found = '0;
      skip_first  = 1'b1;
      cur_freq    = cfg_first;
      cur_lvl     = '0;
      prev_freq   = cfg_first;
      prev_lvl    = '0;
      park_freq   = '0;
      park_lvl    = '0;
      retry_freq  = cfg_first;
      crest_lvl   = '0;
   endfunction

   // Moves the sweep one step; returns 0 when nothing is commanded
   function automatic bit advance_scan();
      if (sticky_err || cur_freq > cfg_last)
         return 1'b0;
      if (mode_now == SCAN_INIT) begin
         mode_now = SCAN_SET;
         cur_freq = cfg_first;
         add_result(plain_result(KIND_SET_FREQ, cur_freq));
         return 1'b1;
      end
      if (mode_now == SCAN_SET) begin
         mode_now = SCAN_GET;
         add_result(plain_result(KIND_GET_LEVEL, '0));
         return 1'b1;
      end
      if (mode_now != SCAN_GET)
         return 1'b0;
      if (cur_lvl == 0) begin
         retry_freq = cur_freq;
         take_sample();
         if (cur_freq >= cfg_last) begin
            end_sweep();
            return 1'b1;
         end
         cur_freq = clip_sum(cur_freq, freq_type'(cfg_big));
      end else begin
         // signal after silence: park the coarse point and go back
         if (cur_freq > retry_freq) begin
            park_freq = cur_freq;
            park_lvl  = cur_lvl;
            cur_freq  = retry_freq;
         end else begin
            take_sample();
         end
         if (cur_freq >= cfg_last) begin
            end_sweep();
            return 1'b1;
         end
         cur_freq = clip_sum(cur_freq, freq_type'(cfg_small));
         // landed on the parked point: reuse its level
         if (cur_freq == park_freq) begin
            cur_lvl = park_lvl;
            take_sample();
            cur_freq = clip_sum(cur_freq, freq_type'(cfg_small));
         end
      end
      mode_now = SCAN_SET;
      if (cur_freq > cfg_last)
         cur_freq = cfg_last;
      if (cur_lvl != 0)
         retry_freq = cur_freq;
      add_result(plain_result(KIND_SET_FREQ, cur_freq));
      return 1'b1;
   endfunction

   // Expected results of one accepted request
   function automatic void predict_item(scan_item_type it);
      bit sent;
      sent = 1'b0;
      step_out.delete();
      if (!sticky_err) begin
         if (it.op == OP_START) begin
            clear_scan();
         end else if (mode_now == SCAN_SET) begin
            if (it.len != ACK_LEN)
               sticky_err = 1'b1;
         end else if (mode_now == SCAN_GET) begin
            if (it.len != LEVEL_LEN) begin
               sticky_err = 1'b1;
            end else if (it.ch == CHAR_SILENT) begin
               cur_lvl = '0;
            end else if (it.ch < CHAR_LEVEL_BASE || it.ch > CHAR_LEVEL_BASE + LEVEL_TOP_OFS) begin
               cur_lvl    = '0;
               sticky_err = 1'b1;
            end else begin
               cur_lvl = level_type'(it.ch - CHAR_LEVEL_BASE + 8'd1);
            end
         end
         if (!sticky_err)
            sent = advance_scan();
      end
      if (!sent)
         add_result(plain_result(KIND_NONE, cur_freq));
      foreach (step_out[k]) begin
         step_out[k].error = sticky_err;
         step_out[k].last  = (k == step_out.size() - 1);
         pending_results.push_back(step_out[k]);
      end
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predict_item(item_on_bus);
         if (!req_tvalid || req_tready) begin
            if (items_to_send.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
               item_on_bus = items_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {item_on_bus.ch, item_on_bus.len};
               req_tuser  <= item_on_bus.op;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response back-pressure, with a long hold when one is asked for
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (holds_served != holds_asked) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction kind %0d freq %0d",
                                      rsp_tuser, rsp_tdata[FREQ_W-1:0]));
         end else begin
            oldest = pending_results.pop_front();
            check_field("kind", rsp_tuser, oldest.kind);
            check_field("freq", rsp_tdata[0 +: FREQ_W], oldest.freq);
            check_field("peak_start_freq", rsp_tdata[SFREQ_LO +: FREQ_W], oldest.start_freq);
            check_field("peak_start_level", rsp_tdata[SLVL_LO +: LEVEL_W], oldest.start_level);
            check_field("peak_top_freq", rsp_tdata[TFREQ_LO +: FREQ_W], oldest.top_freq);
            check_field("peak_power", rsp_tdata[POWER_LO +: LEVEL_W], oldest.power);
            check_field("peak_end_level", rsp_tdata[ELVL_LO +: LEVEL_W], oldest.end_level);
            check_field("peak_index", rsp_tdata[INDEX_LO +: INDEX_W], oldest.index);
            check_field("error", rsp_tdata[RSP_ERROR_BIT], oldest.error);
            check_field("last", rsp_tlast, oldest.last);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] level_char(int lvl);
      return (lvl == 0) ? CHAR_SILENT : CHAR_LEVEL_BASE + 8'(lvl - 1);
   endfunction

   function automatic logic [7:0] rand_level_char(int silent_pct);
      return ($urandom_range(0, 99) < silent_pct) ? CHAR_SILENT
                                                  : level_char($urandom_range(1, 16));
   endfunction

   task automatic add_item(logic op, logic [7:0] len, logic [7:0] ch);
      scan_item_type it;
      it.op  = op;
      it.len = len;
      it.ch  = ch;
      items_to_send.push_back(it);
   endtask

   // Acknowledge of a set-frequency command, then a level reply
   task automatic add_reply_pair(logic [7:0] ch);
      add_item(OP_REPLY, ACK_LEN, rand_byte());
      add_item(OP_REPLY, LEVEL_LEN, ch);
   endtask

   // Well-formed sweep with random levels and the odd restart
   task automatic add_sweep(int replies, int silent_pct);
      int n;
      n = 0;
      add_item(OP_START, rand_byte(), rand_byte());
      while (n < replies) begin
         if ($urandom_range(0, 99) < 3)
            add_item(OP_START, rand_byte(), rand_byte());
         add_reply_pair(rand_level_char(silent_pct));
         n += 2;
      end
   endtask

   // Sender pauses until every expected result has arrived
   task automatic settle();
      do
         @(negedge clock);
      while (items_to_send.size() != 0 || req_tvalid || pending_results.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, freq_type val);
      case (idx)
         CSR_FIRST_FREQ: cfg_first = val;
         CSR_LAST_FREQ:  cfg_last  = val;
         CSR_BIG_STEP:   cfg_big   = val[STEP_W-1:0];
         CSR_SMALL_STEP: cfg_small = val[STEP_W-1:0];
      endcase
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int         dir_levels[6];
      int         small_val;
      logic [7:0] bad_len;
      logic [7:0] bad_ch;

      dir_levels = '{0, 3, 16, 4, 1, 0};
      cfg_first   = FIRST_FREQ_RST;
      cfg_last    = LAST_FREQ_RST;
      cfg_big     = BIG_STEP_RST;
      cfg_small   = SMALL_STEP_RST;
      sticky_err  = 1'b0;
      rise_freq   = '0;
      rise_lvl    = '0;
      crest_freq  = '0;
      clear_scan();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reply in init mode acts as a start, then backup and resample
      write_reg(CSR_LAST_FREQ, 25'd2000);
      add_item(OP_REPLY, 8'd7, 8'h5A);
      foreach (dir_levels[i])
         add_reply_pair(level_char(dir_levels[i]));
      add_item(OP_START, 8'hFF, 8'hFF);
      settle();

      // Zero-width sweep, then a reply after the end
      write_reg(CSR_FIRST_FREQ, 25'd0);
      write_reg(CSR_LAST_FREQ, 25'd0);
      add_item(OP_START, 8'h00, 8'h00);
      add_reply_pair(level_char(16));
      add_item(OP_REPLY, 8'hFF, 8'h00);
      settle();

      // Saturating sums near the top of the frequency range
      write_reg(CSR_FIRST_FREQ, 25'd33554000);
      write_reg(CSR_LAST_FREQ, 25'd33554430);
      write_reg(CSR_BIG_STEP, 25'd1048575);
      write_reg(CSR_SMALL_STEP, 25'd1048575);
      add_item(OP_START, rand_byte(), rand_byte());
      add_reply_pair(level_char(0));
      add_reply_pair(level_char(1));
      add_reply_pair(level_char(2));
      settle();

      // Random sweeps under varied settings
      for (int p = 0; p < 6; p++) begin
         small_val = $urandom_range(1, 300);
         write_reg(CSR_FIRST_FREQ, freq_type'($urandom_range(0, 3000)));
         write_reg(CSR_LAST_FREQ, cfg_first + freq_type'($urandom_range(500, 12000)));
         write_reg(CSR_SMALL_STEP, freq_type'(small_val));
         if ($urandom_range(0, 1))
            write_reg(CSR_BIG_STEP, freq_type'(small_val * $urandom_range(1, 4)));
         else
            write_reg(CSR_BIG_STEP, freq_type'($urandom_range(1, 1500)));
         steady = (p == 1);
         if (p == 3)
            holds_asked++;
         add_sweep(34, $urandom_range(20, 60));
         settle();
         steady = 1'b0;
      end

      // Start beyond the end: every request is answered with nothing sent
      write_reg(CSR_FIRST_FREQ, FREQ_MAX);
      write_reg(CSR_LAST_FREQ, freq_type'($urandom_range(0, 33554430)));
      for (int i = 0; i < 40; i++)
         add_item(($urandom_range(0, 9) == 0) ? OP_START : OP_REPLY, rand_byte(), rand_byte());
      settle();

      // Alternating levels give a peak on every other level reply
      write_reg(CSR_FIRST_FREQ, 25'd0);
      write_reg(CSR_LAST_FREQ, 25'd100000);
      write_reg(CSR_BIG_STEP, 25'd1);
      write_reg(CSR_SMALL_STEP, 25'd1);
      add_item(OP_START, rand_byte(), rand_byte());
      for (int i = 0; i < 60; i++)
         add_reply_pair(level_char((i % 2) ? $urandom_range(9, 16) : $urandom_range(1, 7)));
      settle();

      // One malformed reply sets the sticky error; later requests see it
      add_item(OP_START, rand_byte(), rand_byte());
      case ($urandom_range(0, 2))
         0: add_item(OP_REPLY, 8'($urandom_range(1, 255)), rand_byte());
         1: begin
            bad_len = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(2, 255));
            add_item(OP_REPLY, ACK_LEN, rand_byte());
            add_item(OP_REPLY, bad_len, level_char($urandom_range(0, 16)));
         end
         default: begin
            do
               bad_ch = rand_byte();
            while (bad_ch == CHAR_SILENT ||
                   (bad_ch >= CHAR_LEVEL_BASE && bad_ch <= CHAR_LEVEL_BASE + LEVEL_TOP_OFS));
            add_item(OP_REPLY, ACK_LEN, rand_byte());
            add_item(OP_REPLY, LEVEL_LEN, bad_ch);
         end
      endcase
      for (int i = 0; i < 10; i++)
         add_item(1'($urandom_range(0, 1)), rand_byte(), rand_byte());
      settle();

      repeat (10) @(negedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[adaptive_frequency_scan_peak_finder.f]
rtl/core/afspf_pkg.sv
rtl/core/afspf_detect.sv
rtl/core/afspf_core.sv
rtl/core/afspf_rbuf.sv
rtl/core/adaptive_frequency_scan_peak_finder.sv
rtl/core/afspf_chk.sv
bench/adaptive_frequency_scan_peak_finder_tb.sv
